[design/i2cms_pkg.sv]
`default_nettype none
package i2cms_pkg;

    // Item actions
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_START  = 2'd1,
        ACT_STATUS = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    // Bus commands
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_ACK   = 3'd4,
        CMD_NACK  = 3'd5,
        CMD_CLEAR = 3'd6
    } t_cmd;

    // Completion events
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_TX_DONE = 3'd1,
        EV_RX_DONE = 3'd2,
        EV_NACK    = 3'd3,
        EV_ARB     = 3'd4
    } t_event;

    // Bus status codes, prescaler bits cleared
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_TX_ACK = 8'h28;
    localparam logic [7:0] ST_DATA_TX_NAK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
    localparam logic [7:0] ST_DATA_RX_ACK = 8'h50;
    localparam logic [7:0] ST_DATA_RX_NAK = 8'h58;
    localparam logic [7:0] ST_MASK        = 8'hFC;

    localparam logic [8:0] MAX_LENGTH = 9'd256;

    // One input word
    typedef struct packed {
        t_action    action;
        logic [7:0] buffer_index;
        logic [7:0] buffer_value;
        logic [7:0] address_byte;
        logic       read_not_write;
        logic [8:0] transfer_length;
        logic [7:0] status_code;
        logic [7:0] received_byte;
    } t_item;

    // Buffer access request
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [7:0] idx;
        logic [7:0] wdata;
    } t_buf_req;

    // Result of one word, before buffer data is merged
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] drv;
        logic       drv_from_buf;
        logic       drv_valid;
        t_event     ev;
        logic [8:0] bytes_done;
        logic       is_read;
    } t_step;

endpackage
`default_nettype wire

[design/i2cms_in_if.sv]
`default_nettype none
interface i2cms_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] buffer_index;
    logic [7:0] buffer_value;
    logic [7:0] address_byte;
    logic       read_not_write;
    logic [8:0] transfer_length;
    logic [7:0] status_code;
    logic [7:0] received_byte;

    modport source (
        output valid, action, buffer_index, buffer_value, address_byte,
               read_not_write, transfer_length, status_code, received_byte,
        input  ready
    );
    modport sink (
        input  valid, action, buffer_index, buffer_value, address_byte,
               read_not_write, transfer_length, status_code, received_byte,
        output ready
    );
endinterface
`default_nettype wire

[design/i2cms_out_if.sv]
`default_nettype none
interface i2cms_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_command;
    logic [7:0] drive_byte;
    logic       drive_valid;
    logic [2:0] completion_event;
    logic [8:0] bytes_moved;
    logic [7:0] read_data;

    modport source (
        output valid, bus_command, drive_byte, drive_valid, completion_event,
               bytes_moved, read_data,
        input  ready
    );
    modport sink (
        input  valid, bus_command, drive_byte, drive_valid, completion_event,
               bytes_moved, read_data,
        output ready
    );
endinterface
`default_nettype wire

[design/i2cms_buffer.sv]
`default_nettype none
module i2cms_buffer
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire t_buf_req   i_req,
    output logic [7:0]      o_rdata
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_q;
    logic          r_ok;
    logic [AW+7:0] idx_wide;
    logic [AW-1:0] addr;
    logic          in_range;

    // Map the byte index onto the memory address
    assign idx_wide = {{AW{1'b0}}, i_req.idx};
    assign addr     = idx_wide[AW-1:0];
    assign in_range = (32'(i_req.idx) < BUFFER_DEPTH);

    // Write port: drop stores beyond the buffer
    always_ff @(posedge i_clk) begin
        if (i_req.wr && in_range) begin
            r_mem[addr] <= i_req.wdata;
        end
    end

    // Read port: hold data until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_q  <= r_mem[addr];
            r_ok <= in_range;
        end
    end

    assign o_rdata = r_ok ? r_q : 8'd0;

endmodule
`default_nettype wire

[design/i2cms_ctrl.sv]
`default_nettype none
module i2cms_ctrl
    import i2cms_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_accept,
    input  wire t_item i_item,
    output t_step      o_step,
    output t_buf_req   o_buf_req
);

    logic [7:0] r_addr_dir, n_addr_dir;
    logic [7:0] r_pos,      n_pos;
    logic [8:0] r_left,     n_left;
    logic [8:0] r_done,     n_done;
    logic [7:0] status;
    logic       rx_check;
    t_buf_req   req;

    assign status = i_item.status_code & ST_MASK;

    // Decode one word: next transfer state, command and buffer access
    always_comb begin
        n_addr_dir          = r_addr_dir;
        n_pos               = r_pos;
        n_left              = r_left;
        n_done              = r_done;
        rx_check            = 1'b0;
        o_step.cmd          = CMD_NONE;
        o_step.drv          = 8'd0;
        o_step.drv_from_buf = 1'b0;
        o_step.drv_valid    = 1'b0;
        o_step.ev           = EV_NONE;
        o_step.is_read      = 1'b0;
        req.rd              = 1'b0;
        req.wr              = 1'b0;
        req.idx             = i_item.buffer_index;
        req.wdata           = i_item.buffer_value;

        unique case (i_item.action)
            ACT_LOAD: begin
                req.wr = 1'b1;
            end
            ACT_READ: begin
                req.rd         = 1'b1;
                o_step.is_read = 1'b1;
            end
            ACT_START: begin
                n_addr_dir = {i_item.address_byte[7:1], i_item.read_not_write};
                n_pos      = 8'd0;
                n_left     = (i_item.transfer_length > MAX_LENGTH) ?
                             MAX_LENGTH : i_item.transfer_length;
                n_done     = 9'd0;
                o_step.cmd = CMD_START;
            end
            ACT_STATUS: begin
                unique case (status)
                    ST_START, ST_RESTART: begin
                        o_step.drv       = r_addr_dir;
                        o_step.drv_valid = 1'b1;
                        o_step.cmd       = CMD_SEND;
                    end
                    ST_SLA_W_ACK, ST_DATA_TX_ACK: begin
                        if (r_left != 9'd0) begin
                            req.rd              = 1'b1;
                            req.idx             = r_pos;
                            o_step.drv_from_buf = 1'b1;
                            o_step.drv_valid    = 1'b1;
                            n_pos               = r_pos + 8'd1;
                            n_done              = r_done + 9'd1;
                            n_left              = r_left - 9'd1;
                            o_step.cmd          = CMD_SEND;
                        end else begin
                            o_step.cmd = CMD_STOP;
                            o_step.ev  = EV_TX_DONE;
                        end
                    end
                    ST_DATA_TX_NAK: begin
                        o_step.cmd = CMD_STOP;
                        o_step.ev  = EV_TX_DONE;
                    end
                    ST_SLA_W_NACK, ST_SLA_R_NACK: begin
                        o_step.cmd = CMD_STOP;
                        o_step.ev  = EV_NACK;
                    end
                    ST_ARB_LOST: begin
                        o_step.cmd = CMD_CLEAR;
                        o_step.ev  = EV_ARB;
                    end
                    ST_DATA_RX_ACK, ST_DATA_RX_NAK: begin
                        // Store only while bytes remain
                        if (r_left != 9'd0) begin
                            req.wr    = 1'b1;
                            req.idx   = r_pos;
                            req.wdata = i_item.received_byte;
                            n_pos     = r_pos + 8'd1;
                            n_done    = r_done + 9'd1;
                            n_left    = r_left - 9'd1;
                        end
                        rx_check = 1'b1;
                    end
                    ST_SLA_R_ACK: begin
                        rx_check = 1'b1;
                    end
                    default: begin
                    end
                endcase
                // Pick the next receive command from what remains
                if (rx_check) begin
                    if (n_left > 9'd1) begin
                        o_step.cmd = CMD_ACK;
                    end else if (n_left == 9'd1) begin
                        o_step.cmd = CMD_NACK;
                    end else begin
                        o_step.cmd = CMD_STOP;
                        o_step.ev  = EV_RX_DONE;
                    end
                end
            end
            default: begin
            end
        endcase

        o_step.bytes_done = n_done;
    end

    // Issue buffer access only for an accepted word
    always_comb begin
        o_buf_req    = req;
        o_buf_req.rd = req.rd & i_accept;
        o_buf_req.wr = req.wr & i_accept;
    end

    // Advance transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_dir <= 8'd0;
            r_pos      <= 8'd0;
            r_left     <= 9'd0;
            r_done     <= 9'd0;
        end else if (i_accept) begin
            r_addr_dir <= n_addr_dir;
            r_pos      <= n_pos;
            r_left     <= n_left;
            r_done     <= n_done;
        end
    end

endmodule
`default_nettype wire

[design/i2c_master_transfer_sequencer.sv]
// I2C master transfer sequencer.
// Input channel i_in carries one word per item: a buffer load, a buffer read,
// a transfer start (address, direction, length) or a bus status code with the
// received byte. Output channel o_out returns exactly one word per input word:
// bus command, byte to drive, completion event, bytes moved, read data.
// Both channels use valid/ready; a word moves when both are high.
// Pipeline: two register stages (synchronous buffer read, output register);
// an accepted word waits in the middle stage with its buffer read, then moves
// to the output register, where o_out.valid rises and the word can be taken.
// Throughput: one word per cycle while o_out.ready stays high, set by the
// single-port byte buffer that is read or written at most once per accepted word.
// A held output does not stop input at once: one more word is taken into the
// middle stage if it is empty, then i_in.ready drops until o_out.ready returns.
// Reset clears the address, position and counters and empties both stages.
// The byte buffer is not cleared; no clearing pass is run after reset.
`default_nettype none
module i2c_master_transfer_sequencer
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    i2cms_in_if.sink    i_in,
    i2cms_out_if.source o_out
);

    t_item      item;
    t_step      step;
    t_buf_req   buf_req;
    logic [7:0] buf_rdata;
    logic       accept;
    logic       p1_move;

    logic       r_p1_valid;
    t_step      r_p1;
    logic       r_o_valid;
    t_cmd       r_o_cmd;
    logic [7:0] r_o_drive_byte;
    logic       r_o_drive_valid;
    t_event     r_o_event;
    logic [8:0] r_o_bytes;
    logic [7:0] r_o_read_data;

    // Gather the input word
    always_comb begin
        item.action          = t_action'(i_in.action);
        item.buffer_index    = i_in.buffer_index;
        item.buffer_value    = i_in.buffer_value;
        item.address_byte    = i_in.address_byte;
        item.read_not_write  = i_in.read_not_write;
        item.transfer_length = i_in.transfer_length;
        item.status_code     = i_in.status_code;
        item.received_byte   = i_in.received_byte;
    end

    // Handshake between the stages
    assign p1_move    = r_p1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_p1_valid || p1_move;
    assign accept     = i_in.valid && i_in.ready;

    i2cms_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (item),
        .o_step    (step),
        .o_buf_req (buf_req)
    );

    i2cms_buffer #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_req   (buf_req),
        .o_rdata (buf_rdata)
    );

    // Hold the decoded word while the buffer read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= accept || (r_p1_valid && !p1_move);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1 <= step;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p1_move) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Merge buffer data into the result word
    always_ff @(posedge i_clk) begin
        if (p1_move) begin
            r_o_cmd         <= r_p1.cmd;
            r_o_drive_byte  <= r_p1.drv_from_buf ? buf_rdata : r_p1.drv;
            r_o_drive_valid <= r_p1.drv_valid;
            r_o_event       <= r_p1.ev;
            r_o_bytes       <= r_p1.bytes_done;
            r_o_read_data   <= r_p1.is_read ? buf_rdata : 8'd0;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.bus_command      = r_o_cmd;
    assign o_out.drive_byte       = r_o_drive_byte;
    assign o_out.drive_valid      = r_o_drive_valid;
    assign o_out.completion_event = r_o_event;
    assign o_out.bytes_moved      = r_o_bytes;
    assign o_out.read_data        = r_o_read_data;

endmodule
`default_nettype wire

[design/i2cms_checker.sv]
`default_nettype none
module i2cms_checker
    import i2cms_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_cmd,
    input wire logic [7:0] i_drive_byte,
    input wire logic       i_drive_valid,
    input wire logic [2:0] i_event,
    input wire logic [8:0] i_bytes,
    input wire logic [7:0] i_read_data
);

    // Stalled result word keeps valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    // Stalled result word keeps its payload (all but drive_valid)
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_cmd) && $stable(i_drive_byte) && $stable(i_event)
            && $stable(i_bytes) && $stable(i_read_data))
        else $error("result payload changed while stalled");

    // A driven byte comes only with a send command
    a_drive_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_drive_valid |-> i_cmd == CMD_SEND)
        else $error("drive byte without send command");

    // Events come with stop or clear only
    a_event_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event != EV_NONE |->
            (i_cmd == CMD_STOP || i_cmd == CMD_CLEAR))
        else $error("completion event with wrong command");

    // A start restarts the byte count and drives no byte
    a_start_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_cmd == CMD_START |-> i_bytes == 9'd0 && !i_drive_valid)
        else $error("start word with nonzero byte count");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_i2cms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_cmd         (o_out.bus_command),
    .i_drive_byte  (o_out.drive_byte),
    .i_drive_valid (o_out.drive_valid),
    .i_event       (o_out.completion_event),
    .i_bytes       (o_out.bytes_moved),
    .i_read_data   (o_out.read_data)
);
`default_nettype wire

[dv/tb_i2c_master_transfer_sequencer.sv]
`default_nettype none
module tb_i2c_master_transfer_sequencer
    import i2cms_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 150;
    // Masks to a code the block does not know
    localparam logic [7:0] UNKNOWN_STATUS = 8'hFF;

    // One result word as the block should return it
    typedef struct {
        t_cmd       cmd;
        logic [7:0] drv;
        logic       drv_valid;
        t_event     ev;
        logic [8:0] moved;
        logic [7:0] rdata;
    } t_seq_result;

    logic i_clk;
    logic i_rst_n;

    i2cms_in_if  in_if ();
    i2cms_out_if out_if ();

    i2c_master_transfer_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted transfer state
    logic [7:0] addr_dir;
    logic [7:0] xfer_pos;
    logic [8:0] xfer_left;
    logic [8:0] xfer_done;
    logic [7:0] byte_store [256];
    bit         store_written [256];

    t_seq_result pending_results [$];
    int          fail_count;
    int          cycle_count;
    int          words_sent;
    bit          steady_traffic;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Work out the result of one word and advance the predicted state
    function automatic t_seq_result predict_sequencer(input t_item w);
        t_seq_result r;
        logic [7:0]  st;
        bit          rx_check;
        r.cmd       = CMD_NONE;
        r.drv       = 8'd0;
        r.drv_valid = 1'b0;
        r.ev        = EV_NONE;
        r.rdata     = 8'd0;
        rx_check    = 1'b0;
        st          = w.status_code & ST_MASK;
        case (w.action)
            ACT_LOAD: begin
                byte_store[w.buffer_index]    = w.buffer_value;
                store_written[w.buffer_index] = 1'b1;
            end
            ACT_READ: begin
                r.rdata = byte_store[w.buffer_index];
            end
            ACT_START: begin
                addr_dir  = {w.address_byte[7:1], w.read_not_write};
                xfer_pos  = 8'd0;
                xfer_left = (w.transfer_length > MAX_LENGTH) ? MAX_LENGTH : w.transfer_length;
                xfer_done = 9'd0;
                r.cmd     = CMD_START;
            end
            default: begin
                case (st)
                    ST_START, ST_RESTART: begin
                        r.drv       = addr_dir;
                        r.drv_valid = 1'b1;
                        r.cmd       = CMD_SEND;
                    end
                    ST_SLA_W_ACK, ST_DATA_TX_ACK: begin
                        if (xfer_left != 0) begin
                            r.drv       = byte_store[xfer_pos];
                            r.drv_valid = 1'b1;
                            r.cmd       = CMD_SEND;
                            xfer_pos++;
                            xfer_done++;
                            xfer_left--;
                        end else begin
                            r.cmd = CMD_STOP;
                            r.ev  = EV_TX_DONE;
                        end
                    end
                    ST_DATA_TX_NAK: begin
                        r.cmd = CMD_STOP;
                        r.ev  = EV_TX_DONE;
                    end
                    ST_SLA_W_NACK, ST_SLA_R_NACK: begin
                        r.cmd = CMD_STOP;
                        r.ev  = EV_NACK;
                    end
                    ST_ARB_LOST: begin
                        r.cmd = CMD_CLEAR;
                        r.ev  = EV_ARB;
                    end
                    ST_DATA_RX_ACK, ST_DATA_RX_NAK: begin
                        // Store only while bytes remain
                        if (xfer_left != 0) begin
                            byte_store[xfer_pos]    = w.received_byte;
                            store_written[xfer_pos] = 1'b1;
                            xfer_pos++;
                            xfer_done++;
                            xfer_left--;
                        end
                        rx_check = 1'b1;
                    end
                    ST_SLA_R_ACK: begin
                        rx_check = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (rx_check) begin
                    if (xfer_left > 1) begin
                        r.cmd = CMD_ACK;
                    end else if (xfer_left == 1) begin
                        r.cmd = CMD_NACK;
                    end else begin
                        r.cmd = CMD_STOP;
                        r.ev  = EV_RX_DONE;
                    end
                end
            end
        endcase
        r.moved = xfer_done;
        return r;
    endfunction

    function automatic t_item random_word();
        t_item w;
        w.action          = t_action'($urandom_range(0, 3));
        w.buffer_index    = 8'($urandom_range(0, 255));
        w.buffer_value    = 8'($urandom_range(0, 255));
        w.address_byte    = 8'($urandom_range(0, 255));
        w.read_not_write  = 1'($urandom_range(0, 1));
        w.transfer_length = 9'($urandom_range(0, 511));
        w.status_code     = 8'($urandom_range(0, 255));
        w.received_byte   = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // Drive one word, hold it until accepted, then log its expected result
    task automatic send_word(input t_item w);
        int gap;
        @(negedge i_clk);
        if (!steady_traffic && $urandom_range(0, 99) < 2) begin
            gap = $urandom_range(1, 6);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.action          <= w.action;
        in_if.buffer_index    <= w.buffer_index;
        in_if.buffer_value    <= w.buffer_value;
        in_if.address_byte    <= w.address_byte;
        in_if.read_not_write  <= w.read_not_write;
        in_if.transfer_length <= w.transfer_length;
        in_if.status_code     <= w.status_code;
        in_if.received_byte   <= w.received_byte;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_results.push_back(predict_sequencer(w));
        words_sent++;
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_for_drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [7:0] val);
        t_item w;
        w              = random_word();
        w.action       = ACT_LOAD;
        w.buffer_index = idx;
        w.buffer_value = val;
        send_word(w);
    endtask

    // Read back the first written entry at or after idx
    task automatic send_read(input logic [7:0] idx);
        t_item      w;
        logic [7:0] pick;
        pick = idx;
        for (int k = 0; k < 256; k++) begin
            if (store_written[pick]) break;
            pick++;
        end
        w              = random_word();
        w.action       = ACT_READ;
        w.buffer_index = pick;
        send_word(w);
    endtask

    task automatic send_start(input logic [7:0] addr, input logic rnw, input logic [8:0] len);
        t_item w;
        w                 = random_word();
        w.action          = ACT_START;
        w.address_byte    = addr;
        w.read_not_write  = rnw;
        w.transfer_length = len;
        send_word(w);
    endtask

    // Status word with random prescaler bits; fill the send position first if empty
    task automatic send_status(input logic [7:0] code);
        t_item      w;
        logic [7:0] masked;
        masked = code & ST_MASK;
        if ((masked == ST_SLA_W_ACK || masked == ST_DATA_TX_ACK) && xfer_left != 0
                && !store_written[xfer_pos]) begin
            send_load(xfer_pos, 8'($urandom_range(0, 255)));
        end
        w             = random_word();
        w.action      = ACT_STATUS;
        w.status_code = {code[7:2], 2'($urandom_range(0, 3))};
        send_word(w);
    endtask

    // Any kind of word, out of sequence
    task automatic send_noise();
        case ($urandom_range(0, 7))
            0, 1: send_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            2, 3: send_read(8'($urandom_range(0, 255)));
            4: send_start(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          9'($urandom_range(0, 511)));
            default: send_status(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic test_buffer_access();
        send_load(8'h00, 8'h00);
        send_load(8'hFF, 8'hFF);
        send_load(8'h55, 8'hAA);
        send_read(8'h00);
        send_read(8'hFF);
        send_read(8'h55);
    endtask

    task automatic test_transmit_codes();
        send_start(8'hFF, 1'b0, 9'd2);
        send_status(ST_START);
        send_status(ST_SLA_W_ACK);
        send_status(ST_DATA_TX_ACK);
        // Nothing left: stop with transmit complete
        send_status(ST_DATA_TX_ACK);
        send_status(ST_DATA_TX_NAK);
        send_status(ST_SLA_W_NACK);
        send_status(ST_SLA_R_NACK);
        send_status(ST_ARB_LOST);
        send_status(UNKNOWN_STATUS);
    endtask

    task automatic test_receive_codes();
        send_start(8'h00, 1'b1, 9'd2);
        send_status(ST_RESTART);
        send_status(ST_SLA_R_ACK);
        send_status(ST_DATA_RX_ACK);
        send_status(ST_DATA_RX_NAK);
        // Receive with nothing left: no store, stop with receive complete
        send_status(ST_DATA_RX_NAK);
        send_status(ST_DATA_RX_ACK);
        send_read(8'h01);
        // Overlong length saturates
        send_start(8'h81, 1'b1, 9'h1FF);
        send_status(ST_SLA_R_ACK);
        send_start(8'h7E, 1'b1, 9'd0);
        send_status(ST_SLA_R_ACK);
    endtask

    // Full-length transfers both ways so the position wraps, with no idling;
    // receive first so every buffer entry is filled before the transmit
    task automatic test_position_wrap();
        steady_traffic = 1'b1;
        send_start(8'($urandom_range(0, 255)), 1'b1, 9'($urandom_range(257, 511)));
        send_status(ST_START);
        send_status(ST_SLA_R_ACK);
        while (xfer_left != 0) begin
            send_status((xfer_left == 1) ? ST_DATA_RX_NAK : ST_DATA_RX_ACK);
        end
        send_status(ST_DATA_RX_ACK);
        send_start(8'($urandom_range(0, 255)), 1'b0, MAX_LENGTH);
        send_status(ST_START);
        send_status(ST_SLA_W_ACK);
        while (xfer_left != 0) send_status(ST_DATA_TX_ACK);
        send_status(ST_DATA_TX_ACK);
        steady_traffic = 1'b0;
        wait_for_drain();
    endtask

    // One well-formed transfer with random content and occasional breaks
    task automatic run_random_transfer();
        logic       rnw;
        logic [8:0] len;
        int         r;
        rnw = 1'($urandom_range(0, 1));
        r   = $urandom_range(0, 99);
        if (r < 85)      len = 9'($urandom_range(0, 8));
        else if (r < 98) len = 9'($urandom_range(9, 40));
        else             len = 9'($urandom_range(200, 511));
        send_start(8'($urandom_range(0, 255)), rnw, len);
        send_status(($urandom_range(0, 3) == 0) ? ST_RESTART : ST_START);
        r = $urandom_range(0, 99);
        if (!rnw) begin
            if (r < 8) begin
                send_status(ST_SLA_W_NACK);
                return;
            end
            if (r < 12) begin
                send_status(ST_ARB_LOST);
                return;
            end
            send_status(ST_SLA_W_ACK);
            while (xfer_left != 0) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    send_status(ST_DATA_TX_NAK);
                    return;
                end
                if (r < 5) begin
                    send_status(ST_ARB_LOST);
                    return;
                end
                if (r < 10) send_noise();
                send_status(ST_DATA_TX_ACK);
            end
            send_status(($urandom_range(0, 3) == 0) ? ST_DATA_TX_NAK : ST_DATA_TX_ACK);
        end else begin
            if (r < 8) begin
                send_status(ST_SLA_R_NACK);
                return;
            end
            if (r < 12) begin
                send_status(ST_ARB_LOST);
                return;
            end
            send_status(ST_SLA_R_ACK);
            while (xfer_left != 0) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    send_status(ST_ARB_LOST);
                    return;
                end
                if (r < 8) send_noise();
                send_status((xfer_left == 1) ? ST_DATA_RX_NAK : ST_DATA_RX_ACK);
            end
            if ($urandom_range(0, 3) == 0) begin
                send_status(($urandom_range(0, 1) == 0) ? ST_DATA_RX_ACK : ST_DATA_RX_NAK);
            end
            repeat ($urandom_range(0, 2)) send_read(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic();
        int base;
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            if ($urandom_range(0, 99) < 15) send_noise();
            else run_random_transfer();
            if ($urandom_range(0, 99) < 4) wait_for_drain();
        end
    endtask

    // Result side stalls: mostly short, now and then a longer hold
    initial begin : sink_stall
        int stall;
        stall        = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else if (steady_traffic) begin
                out_if.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 5) begin
                out_if.ready <= 1'b0;
                if ($urandom_range(0, 9) == 0) stall = $urandom_range(2, 15);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Compare each result word with the oldest expectation
    task automatic check_field(input string field, input logic [8:0] want,
                               input logic [8:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_seq_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result word with none expected, actual command %0d",
                         $time, out_if.bus_command);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("bus_command", 9'(want.cmd), 9'(out_if.bus_command));
                check_field("drive_byte", 9'(want.drv), 9'(out_if.drive_byte));
                check_field("drive_valid", 9'(want.drv_valid), 9'(out_if.drive_valid));
                check_field("completion_event", 9'(want.ev), 9'(out_if.completion_event));
                check_field("bytes_moved", want.moved, out_if.bytes_moved);
                check_field("read_data", 9'(want.rdata), 9'(out_if.read_data));
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** i2c_master_transfer_sequencer: FAILED **");
        $finish;
    end

    initial begin
        addr_dir       = 8'd0;
        xfer_pos       = 8'd0;
        xfer_left      = 9'd0;
        xfer_done      = 9'd0;
        fail_count     = 0;
        words_sent     = 0;
        steady_traffic = 1'b0;
        for (int k = 0; k < 256; k++) begin
            byte_store[k]    = 8'd0;
            store_written[k] = 1'b0;
        end
        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.action          = ACT_LOAD;
        in_if.buffer_index    = 8'd0;
        in_if.buffer_value    = 8'd0;
        in_if.address_byte    = 8'd0;
        in_if.read_not_write  = 1'b0;
        in_if.transfer_length = 9'd0;
        in_if.status_code     = 8'd0;
        in_if.received_byte   = 8'd0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_buffer_access();
        test_transmit_codes();
        test_receive_codes();
        wait_for_drain();
        test_position_wrap();
        test_random_traffic();

        // Let the pipeline empty, then wait for stray words
        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("** i2c_master_transfer_sequencer: PASSED **");
        end else begin
            $display("** i2c_master_transfer_sequencer: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
